[design/chs_pkg.sv]
// Shared types and constants of the cosine-weighted hemisphere sampler.
`default_nettype none

package chs_pkg;

  localparam int FRAC_BITS = 14;
  localparam int VW        = 16;

  typedef struct packed {
    logic signed [VW-1:0] normal_x;
    logic signed [VW-1:0] normal_y;
    logic signed [VW-1:0] normal_z;
    logic signed [VW-1:0] out_x;
    logic signed [VW-1:0] out_y;
    logic signed [VW-1:0] out_z;
    logic [15:0]          u_radius;
    logic [15:0]          u_angle;
  } chs_req_t;

  typedef struct packed {
    logic signed [VW-1:0] dir_x;
    logic signed [VW-1:0] dir_y;
    logic signed [VW-1:0] dir_z;
  } chs_rsp_t;

endpackage

`default_nettype wire

[design/cosine_hemisphere_sampler_top.sv]
// Cosine-weighted hemisphere sampler: Frisvad frame, sqrt radius, polynomial sin/cos.
//
// A request carries a unit normal, an outgoing direction and two Q0.16 uniform
// numbers; the response is one sampled direction in signed Q1.14.
// Both channels are valid/ready. A request is taken when req_valid_i and
// req_ready_o are high at a rising edge; the response is taken likewise.
// The datapath is a 21-stage pipeline with the valid bit travelling beside the
// data. With no back-pressure on the response side, one request is taken every cycle.
// The depth is set by the sin/cos polynomial: five Horner steps of three
// stages each (multiply, reciprocal multiply, remainder correction).
// When the final stage holds a response that is not taken, the whole pipeline
// holds and req_ready_o drops; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload registers
// are not reset. There is no configuration and no state between requests.
`default_nettype none

module cosine_hemisphere_sampler_top import chs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  chs_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output chs_rsp_t rsp_o
);

  localparam int F     = FRAC_BITS;
  localparam int ONE_I = 1 << F;
  localparam int LAST  = 20;
  localparam logic signed [VW-1:0] ONE_V = VW'(ONE_I);
  // frame divider
  localparam int DW     = F + 2;
  localparam int QB     = F + 2;
  localparam int NUMW   = 2 * F + 2;
  localparam int CW     = DW + QB + 1;
  localparam int DV0    = 3;
  localparam int DV_STG = (QB + 1) / 2;
  localparam int DV_LAST = DV0 + DV_STG - 1;
  localparam int FR     = DV_LAST + 1;
  localparam logic signed [DW:0] DEG_LIM = (DW+1)'((1 << F) / 10000000);
  // square roots
  localparam int RW     = F + 1;
  localparam int SW2    = 2 * F + 2;
  localparam int SQ_STG = (RW + 1) / 2;
  // sin/cos
  localparam int XW = 30;
  localparam logic [30:0] Q30    = 31'h4000_0000;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam int SH = 30 - F;
  localparam int S_DIV [4] = '{72, 42, 20, 6};
  localparam int C_DIV [5] = '{90, 56, 30, 12, 2};

  function automatic logic signed [VW-1:0] rnd_sat(input logic signed [47:0] v);
    logic [47:0] mag;
    logic [47:0] rs;
    logic signed [VW-1:0] o;
    mag = v[47] ? 48'(-v) : 48'(v);
    rs  = (mag + 48'(1 << (F - 1))) >> F;
    if (rs > 48'(ONE_I)) rs = 48'(ONE_I);
    o = $signed(VW'(rs));
    if (v[47]) o = -o;
    return o;
  endfunction

  logic adv;
  logic [LAST:0] vld_q;

  assign adv         = !vld_q[LAST] || rsp_ready_i;
  assign req_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAST-1:0], req_valid_i};
    end
  end

  // ---------------- stage 0: clamp, dot terms, angle reduction
  logic signed [VW-1:0]   nin_c [3];
  logic signed [VW-1:0]   wo_c  [3];
  logic signed [VW-1:0]   ncl_c [3];
  logic signed [2*VW-1:0] dp_c  [3];
  logic [13:0]            ang_c;
  logic                   sw_c;
  logic [14:0]            y_c;
  logic [46:0]            xm_c;

  logic signed [VW-1:0]   n0_q  [3];
  logic signed [2*VW-1:0] dp0_q [3];
  logic [XW-1:0]          x_q   [0:13];
  logic [XW-1:0]          x2_q  [1:13];
  logic [1:0]             qd_q  [0:16];
  logic                   sw_q  [0:16];

  always_comb begin
    nin_c[0] = req_i.normal_x;
    nin_c[1] = req_i.normal_y;
    nin_c[2] = req_i.normal_z;
    wo_c[0]  = req_i.out_x;
    wo_c[1]  = req_i.out_y;
    wo_c[2]  = req_i.out_z;
    for (int i = 0; i < 3; i++) begin
      if (nin_c[i] > ONE_V) ncl_c[i] = ONE_V;
      else if (nin_c[i] < -ONE_V) ncl_c[i] = -ONE_V;
      else ncl_c[i] = nin_c[i];
      dp_c[i] = ncl_c[i] * wo_c[i];
    end
    ang_c = req_i.u_angle[13:0];
    sw_c  = ang_c > 14'h2000;
    y_c   = sw_c ? 15'h4000 - {1'b0, ang_c} : {1'b0, ang_c};
    xm_c  = 47'(y_c) * 47'(PI_Q30) + 47'(1 << 14);
  end

  // ---------------- stages 1, 2: flip, degenerate test, frame products
  logic signed [VW-1:0]   n1_c [3];
  logic signed [2*VW+1:0] dot_c;
  logic signed [DW:0]     dz_c;
  logic [59:0]            xx_c;

  logic signed [VW-1:0]   n1_q [3];
  logic [DW-1:0]          d1_q;
  logic                   deg1_q;
  logic signed [VW-1:0]   n2_q [3];
  logic [DW-1:0]          d2_q;
  logic                   deg2_q;
  logic signed [2*VW-1:0] pr2_q [3];

  always_comb begin
    dot_c = (2*VW+2)'(dp0_q[0]) + (2*VW+2)'(dp0_q[1]) + (2*VW+2)'(dp0_q[2]);
    for (int i = 0; i < 3; i++) begin
      n1_c[i] = dot_c[2*VW+1] ? -n0_q[i] : n0_q[i];
    end
    dz_c = (DW+1)'(n1_c[2]) + (DW+1)'(ONE_I);
    xx_c = 60'(x_q[0]) * 60'(x_q[0]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n0_q  <= ncl_c;
      dp0_q <= dp_c;
      x_q[0]  <= xm_c[44:15];
      qd_q[0] <= req_i.u_angle[15:14];
      sw_q[0] <= sw_c;
      n1_q   <= n1_c;
      d1_q   <= DW'(dz_c);
      deg1_q <= dz_c <= DEG_LIM;
      x2_q[1] <= xx_c[59:30];
      n2_q   <= n1_q;
      d2_q   <= d1_q;
      deg2_q <= deg1_q;
      pr2_q[0] <= n1_q[0] * n1_q[1];
      pr2_q[1] <= n1_q[0] * n1_q[0];
      pr2_q[2] <= n1_q[1] * n1_q[1];
      for (int s = 1; s <= 13; s++) x_q[s] <= x_q[s-1];
      for (int s = 2; s <= 13; s++) x2_q[s] <= x2_q[s-1];
      for (int s = 1; s <= 16; s++) begin
        qd_q[s] <= qd_q[s-1];
        sw_q[s] <= sw_q[s-1];
      end
    end
  end

  // ---------------- frame divider: lanes xy, xx, yy; two quotient bits a stage
  logic [NUMW-1:0]      dv_rem_q [DV0:DV_LAST][3];
  logic [QB-1:0]        dv_quo_q [DV0:DV_LAST][3];
  logic                 dv_ovf_q [DV0:DV_LAST][3];
  logic                 dv_neg_q [DV0:DV_LAST][3];
  logic signed [VW-1:0] dv_n_q   [DV0:DV_LAST][3];
  logic [DW-1:0]        dv_d_q   [DV0:DV_LAST];
  logic                 dv_deg_q [DV0:DV_LAST];

  for (genvar s = DV0; s <= DV_LAST; s++) begin : g_div
    logic [NUMW-1:0]      rem_i [3];
    logic [QB-1:0]        quo_i [3];
    logic                 ovf_i [3];
    logic                 neg_i [3];
    logic signed [VW-1:0] n_i   [3];
    logic [DW-1:0]        d_i;
    logic                 deg_i;
    logic [NUMW-1:0]      rem_c [3];
    logic [QB-1:0]        quo_c [3];

    if (s == DV0) begin : g_in
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          neg_i[l] = pr2_q[l][2*VW-1];
          rem_i[l] = NUMW'(neg_i[l] ? -pr2_q[l] : pr2_q[l]) + NUMW'(d2_q >> 1);
          ovf_i[l] = CW'(rem_i[l]) >= (CW'(d2_q) << QB);
          quo_i[l] = '0;
        end
        n_i   = n2_q;
        d_i   = d2_q;
        deg_i = deg2_q;
      end
    end else begin : g_in
      always_comb begin
        rem_i = dv_rem_q[s-1];
        quo_i = dv_quo_q[s-1];
        ovf_i = dv_ovf_q[s-1];
        neg_i = dv_neg_q[s-1];
        n_i   = dv_n_q[s-1];
        d_i   = dv_d_q[s-1];
        deg_i = dv_deg_q[s-1];
      end
    end

    always_comb begin
      int k;
      logic [CW-1:0] sub;
      rem_c = rem_i;
      quo_c = quo_i;
      for (int j = 0; j < 2; j++) begin
        k = QB - 1 - 2 * (s - DV0) - j;
        if (k >= 0) begin
          sub = CW'(d_i) << k;
          for (int l = 0; l < 3; l++) begin
            if (CW'(rem_c[l]) >= sub) begin
              rem_c[l] = rem_c[l] - NUMW'(sub);
              quo_c[l][k] = 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[s] <= rem_c;
        dv_quo_q[s] <= quo_c;
        dv_ovf_q[s] <= ovf_i;
        dv_neg_q[s] <= neg_i;
        dv_n_q[s]   <= n_i;
        dv_d_q[s]   <= d_i;
        dv_deg_q[s] <= deg_i;
      end
    end
  end

  // ---------------- frame assembly
  logic [QB-1:0]        mxy_c, mxx_c, myy_c;
  logic signed [VW+1:0] qs_c, tx_c, by_c;
  logic signed [VW-1:0] bb_c;
  logic signed [VW-1:0] t_c [3];
  logic signed [VW-1:0] b_c [3];

  logic signed [VW-1:0] t_q  [FR:18][3];
  logic signed [VW-1:0] b_q  [FR:18][3];
  logic signed [VW-1:0] nf_q [FR:18][3];

  always_comb begin
    mxy_c = (dv_ovf_q[DV_LAST][0] || dv_quo_q[DV_LAST][0] > QB'(ONE_I))
            ? QB'(ONE_I) : dv_quo_q[DV_LAST][0];
    mxx_c = (dv_ovf_q[DV_LAST][1] || dv_quo_q[DV_LAST][1] > QB'(2 * ONE_I))
            ? QB'(2 * ONE_I) : dv_quo_q[DV_LAST][1];
    myy_c = (dv_ovf_q[DV_LAST][2] || dv_quo_q[DV_LAST][2] > QB'(2 * ONE_I))
            ? QB'(2 * ONE_I) : dv_quo_q[DV_LAST][2];
    qs_c  = dv_neg_q[DV_LAST][0] ? -$signed({2'b0, mxy_c}) : $signed({2'b0, mxy_c});
    bb_c  = VW'(-qs_c);
    tx_c  = $signed((VW+2)'(ONE_I)) - $signed({2'b0, mxx_c});
    by_c  = $signed((VW+2)'(ONE_I)) - $signed({2'b0, myy_c});
    if (dv_deg_q[DV_LAST]) begin
      t_c[0] = '0;      t_c[1] = -ONE_V; t_c[2] = '0;
      b_c[0] = -ONE_V;  b_c[1] = '0;     b_c[2] = '0;
    end else begin
      t_c[0] = VW'(tx_c);
      t_c[1] = bb_c;
      t_c[2] = -dv_n_q[DV_LAST][0];
      b_c[0] = bb_c;
      b_c[1] = VW'(by_c);
      b_c[2] = -dv_n_q[DV_LAST][1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q[FR]  <= t_c;
      b_q[FR]  <= b_c;
      nf_q[FR] <= dv_n_q[DV_LAST];
      for (int s = FR + 1; s <= 18; s++) begin
        t_q[s]  <= t_q[s-1];
        b_q[s]  <= b_q[s-1];
        nf_q[s] <= nf_q[s-1];
      end
    end
  end

  // ---------------- square roots of u1 and 1-u1, two root bits a stage
  logic [SW2-1:0] sq_v_q   [0:SQ_STG-1][2];
  logic [SW2-1:0] sq_res_q [0:SQ_STG-1][2];
  logic [RW-1:0]  r_q [SQ_STG:17];
  logic [RW-1:0]  h_q [SQ_STG:18];

  for (genvar s = 0; s < SQ_STG; s++) begin : g_sqrt
    logic [SW2-1:0] v_i [2];
    logic [SW2-1:0] r_i [2];
    logic [SW2-1:0] v_c [2];
    logic [SW2-1:0] r_c [2];

    if (s == 0) begin : g_in
      always_comb begin
        v_i[0] = SW2'(req_i.u_radius) << (2 * F - 16);
        v_i[1] = SW2'(17'h1_0000 - 17'(req_i.u_radius)) << (2 * F - 16);
        r_i[0] = '0;
        r_i[1] = '0;
      end
    end else begin : g_in
      always_comb begin
        v_i = sq_v_q[s-1];
        r_i = sq_res_q[s-1];
      end
    end

    always_comb begin
      int k;
      logic [SW2-1:0] bitv;
      v_c = v_i;
      r_c = r_i;
      for (int j = 0; j < 2; j++) begin
        k = RW - 1 - 2 * s - j;
        if (k >= 0) begin
          bitv = SW2'(1) << (2 * k);
          for (int l = 0; l < 2; l++) begin
            if (v_c[l] >= r_c[l] + bitv) begin
              v_c[l] = v_c[l] - (r_c[l] + bitv);
              r_c[l] = (r_c[l] >> 1) + bitv;
            end else begin
              r_c[l] = r_c[l] >> 1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_v_q[s]   <= v_c;
        sq_res_q[s] <= r_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q[SQ_STG] <= RW'(sq_res_q[SQ_STG-1][0]);
      h_q[SQ_STG] <= RW'(sq_res_q[SQ_STG-1][1]);
      for (int s = SQ_STG + 1; s <= 17; s++) r_q[s] <= r_q[s-1];
      for (int s = SQ_STG + 1; s <= 18; s++) h_q[s] <= h_q[s-1];
    end
  end

  // ---------------- sin/cos Horner steps: multiply, reciprocal, correct
  logic [30:0] as_q [5];
  logic [30:0] ac_q [5];

  for (genvar j = 0; j < 5; j++) begin : g_slot
    localparam int SA = 2 + 3 * j;
    localparam logic [30:0] MC = 31'(64'd2147483648 / 64'(C_DIV[j]));
    logic [30:0]   acs_i, acc_i;
    logic [XW-1:0] mul_s;
    logic [60:0]   mps, mpc;
    logic [61:0]   mec;
    logic [37:0]   edc;
    logic [30:0]   rrc;
    logic [30:0]   ps_q, pc_q, pc1_q, ec_q;

    if (j == 0) begin : g_acc
      assign acs_i = Q30;
      assign acc_i = Q30;
    end else begin : g_acc
      assign acs_i = as_q[j-1];
      assign acc_i = ac_q[j-1];
    end

    // last sine step multiplies by x instead of x^2
    assign mul_s = (j == 4) ? x_q[SA-1] : x2_q[SA-1];
    assign mps   = 61'(mul_s) * 61'(acs_i);
    assign mpc   = 61'(x2_q[SA-1]) * 61'(acc_i);
    assign mec   = 62'(pc_q) * 62'(MC);
    assign edc   = 38'(ec_q) * 38'(C_DIV[j]);
    assign rrc   = pc1_q - 31'(edc);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ps_q  <= mps[60:30];
        pc_q  <= mpc[60:30];
        ec_q  <= mec[61:31];
        pc1_q <= pc_q;
        ac_q[j] <= Q30 - (ec_q + 31'(rrc >= 31'(C_DIV[j])));
      end
    end

    if (j < 4) begin : g_sdiv
      localparam logic [30:0] MS = 31'(64'd2147483648 / 64'(S_DIV[j]));
      logic [61:0] mes;
      logic [37:0] eds;
      logic [30:0] rrs;
      logic [30:0] ps1_q, es_q;
      assign mes = 62'(ps_q) * 62'(MS);
      assign eds = 38'(es_q) * 38'(S_DIV[j]);
      assign rrs = ps1_q - 31'(eds);
      always_ff @(posedge clk_i) begin
        if (adv) begin
          es_q  <= mes[61:31];
          ps1_q <= ps_q;
          as_q[j] <= Q30 - (es_q + 31'(rrs >= 31'(S_DIV[j])));
        end
      end
    end else begin : g_sdiv
      logic [30:0] ps1_q;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          ps1_q   <= ps_q;
          as_q[j] <= ps1_q;
        end
      end
    end
  end

  // ---------------- stage 17: round to Q1.14, undo octant and quadrant
  logic [30:0]          cr_c, sr_c;
  logic signed [VW-1:0] cq_c, sq_c, cs_c, ss_c;
  logic signed [VW-1:0] co_q, si_q;

  always_comb begin
    cr_c = ac_q[4] + 31'(1 << (SH - 1));
    sr_c = as_q[4] + 31'(1 << (SH - 1));
    cs_c = $signed(VW'(cr_c >> SH));
    ss_c = $signed(VW'(sr_c >> SH));
    cq_c = sw_q[16] ? ss_c : cs_c;
    sq_c = sw_q[16] ? cs_c : ss_c;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      case (qd_q[16])
        2'd0: begin co_q <= cq_c;  si_q <= sq_c;  end
        2'd1: begin co_q <= -sq_c; si_q <= cq_c;  end
        2'd2: begin co_q <= -cq_c; si_q <= -sq_c; end
        default: begin co_q <= sq_c; si_q <= -cq_c; end
      endcase
    end
  end

  // ---------------- stages 18..20: disc point, frame transform, output
  logic signed [VW-1:0]   rc_q, rs_q;
  logic signed [2*VW-1:0] m_q [3][3];
  chs_rsp_t               out_q;
  logic signed [47:0]     acc_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_c[i] = 48'(m_q[i][0]) + 48'(m_q[i][1]) + 48'(m_q[i][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rc_q <= rnd_sat(48'($signed({1'b0, r_q[17]}) * co_q));
      rs_q <= rnd_sat(48'($signed({1'b0, r_q[17]}) * si_q));
      for (int i = 0; i < 3; i++) begin
        m_q[i][0] <= t_q[18][i] * rc_q;
        m_q[i][1] <= b_q[18][i] * rs_q;
        m_q[i][2] <= nf_q[18][i] * $signed({1'b0, h_q[18]});
      end
      out_q.dir_x <= rnd_sat(acc_c[0]);
      out_q.dir_y <= rnd_sat(acc_c[1]);
      out_q.dir_z <= rnd_sat(acc_c[2]);
    end
  end

  assign rsp_valid_o = vld_q[LAST];
  assign rsp_o       = out_q;

  // ---------------- checks
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.dir_x <= ONE_V) && (rsp_o.dir_x >= -ONE_V) &&
                    (rsp_o.dir_y <= ONE_V) && (rsp_o.dir_y >= -ONE_V) &&
                    (rsp_o.dir_z <= ONE_V) && (rsp_o.dir_z >= -ONE_V))
    else $error("response component outside unit range");

  a_sqrt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SQ_STG] |-> (r_q[SQ_STG] <= RW'(ONE_I)) && (h_q[SQ_STG] <= RW'(ONE_I)))
    else $error("square root above one");

  a_square_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DV_LAST] |-> !dv_neg_q[DV_LAST][1] && !dv_neg_q[DV_LAST][2])
    else $error("negative square in frame divider");

  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[17] |-> (co_q <= ONE_V) && (co_q >= -ONE_V) &&
                  (si_q <= ONE_V) && (si_q >= -ONE_V))
    else $error("sin/cos outside unit range");

endmodule

`default_nettype wire

[tb/tb_cosine_hemisphere_sampler_top.sv]
// Self-checking testbench for the cosine-weighted hemisphere sampler, random stalls on both sides.
`default_nettype none

module tb_cosine_hemisphere_sampler_top;
  import chs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE      = longint'(1) << FRAC_BITS;
  localparam longint PI_Q30   = 64'd3373259426;
  localparam longint Q30_ONE  = longint'(1) << 30;
  localparam int     N_RANDOM = 1200;
  localparam int     HOLD_LEN = 300;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     req_valid_i = 1'b0;
  logic     req_ready_o;
  chs_req_t req_i = '0;
  logic     rsp_valid_o;
  logic     rsp_ready_i = 1'b0;
  chs_rsp_t rsp_o;

  chs_req_t pending_reqs[$];
  chs_rsp_t expected_dirs[$];
  int       req_gap = 0;
  int       rsp_stall = 0;
  int       hold_cycles = 0;
  bit       hold_done = 1'b0;
  bit       steady = 1'b0;
  int       n_sent = 0;
  int       n_recv = 0;
  int       n_errors = 0;
  int       n_degenerate = 0;
  int       n_flipped = 0;

  always #2 clk_i = ~clk_i;

  cosine_hemisphere_sampler_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // divide by 2^s, rounding half away from zero
  function automatic longint shr_round(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint div_round(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // cos/sin of one turn * u / 2^16, octant reduced
  function automatic void turn_cos_sin(logic [15:0] u, output longint co, output longint si);
    logic [1:0]           quad;
    longint unsigned      a, y, x, x2, s, c;
    bit                   swap;
    longint               cs, ss, cq, sq;
    quad = u[15:14];
    a    = u[13:0];
    swap = a > 'h2000;
    y    = swap ? 'h4000 - a : a;
    x    = (y * PI_Q30 + (1 << 14)) >> 15;
    x2   = q30_mul(x, x);
    s = Q30_ONE - x2 / 72;
    s = Q30_ONE - q30_mul(x2, s) / 42;
    s = Q30_ONE - q30_mul(x2, s) / 20;
    s = Q30_ONE - q30_mul(x2, s) / 6;
    s = q30_mul(x, s);
    c = Q30_ONE - x2 / 90;
    c = Q30_ONE - q30_mul(x2, c) / 56;
    c = Q30_ONE - q30_mul(x2, c) / 30;
    c = Q30_ONE - q30_mul(x2, c) / 12;
    c = Q30_ONE - q30_mul(x2, c) / 2;
    cs = shr_round(longint'(c), 30 - FRAC_BITS);
    ss = shr_round(longint'(s), 30 - FRAC_BITS);
    cq = swap ? ss : cs;
    sq = swap ? cs : ss;
    case (quad)
      2'd0: begin co = cq;  si = sq;  end
      2'd1: begin co = -sq; si = cq;  end
      2'd2: begin co = -cq; si = -sq; end
      default: begin co = sq; si = -cq; end
    endcase
  endfunction

  function automatic chs_rsp_t sample_dir(chs_req_t r);
    longint nv[3], ov[3], tv[3], bv[3], acc[3];
    longint dot, d, bb, xx, yy, rad, hgt, co, si, rc, rs;
    chs_rsp_t res;
    nv[0] = clamp(longint'(r.normal_x), -ONE, ONE);
    nv[1] = clamp(longint'(r.normal_y), -ONE, ONE);
    nv[2] = clamp(longint'(r.normal_z), -ONE, ONE);
    ov[0] = r.out_x;
    ov[1] = r.out_y;
    ov[2] = r.out_z;
    dot = nv[0] * ov[0] + nv[1] * ov[1] + nv[2] * ov[2];
    if (dot < 0) begin
      n_flipped++;
      for (int i = 0; i < 3; i++) nv[i] = -nv[i];
    end
    if (nv[2] + ONE <= ONE / 10000000) begin
      n_degenerate++;
      tv = '{0, -ONE, 0};
      bv = '{-ONE, 0, 0};
    end else begin
      d  = ONE + nv[2];
      bb = -clamp(div_round(nv[0] * nv[1], d), -ONE, ONE);
      xx = clamp(div_round(nv[0] * nv[0], d), 0, 2 * ONE);
      yy = clamp(div_round(nv[1] * nv[1], d), 0, 2 * ONE);
      tv = '{clamp(ONE - xx, -ONE, ONE), bb, -nv[0]};
      bv = '{bb, clamp(ONE - yy, -ONE, ONE), -nv[1]};
    end
    rad = int_sqrt(longint'(r.u_radius) << (2 * FRAC_BITS - 16));
    hgt = int_sqrt((65536 - longint'(r.u_radius)) << (2 * FRAC_BITS - 16));
    turn_cos_sin(r.u_angle, co, si);
    rc = clamp(shr_round(rad * co, FRAC_BITS), -ONE, ONE);
    rs = clamp(shr_round(rad * si, FRAC_BITS), -ONE, ONE);
    for (int i = 0; i < 3; i++)
      acc[i] = clamp(shr_round(tv[i] * rc + bv[i] * rs + nv[i] * hgt, FRAC_BITS), -ONE, ONE);
    res.dir_x = acc[0][15:0];
    res.dir_y = acc[1][15:0];
    res.dir_z = acc[2][15:0];
    return res;
  endfunction

  function automatic chs_req_t mk_req(int nx, int ny, int nz, int ox, int oy, int oz,
                                      int ur, int ua);
    chs_req_t r;
    r.normal_x = nx[15:0];
    r.normal_y = ny[15:0];
    r.normal_z = nz[15:0];
    r.out_x    = ox[15:0];
    r.out_y    = oy[15:0];
    r.out_z    = oz[15:0];
    r.u_radius = ur[15:0];
    r.u_angle  = ua[15:0];
    return r;
  endfunction

  function automatic int in_range();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic chs_req_t random_req();
    int   kind, nx, ny, nz, ox, oy, oz;
    real  fx, fy, fz, len;
    kind = $urandom_range(0, 99);
    fx = in_range();
    fy = in_range();
    fz = in_range();
    len = $sqrt(fx * fx + fy * fy + fz * fz);
    if (len < 1.0) begin
      fx = 0.0; fy = 0.0; fz = 16384.0; len = 16384.0;
    end
    nx = $rtoi(fx * 16384.0 / len);
    ny = $rtoi(fy * 16384.0 / len);
    nz = $rtoi(fz * 16384.0 / len);
    if (kind < 10) begin
      nx = in_range(); ny = in_range(); nz = in_range();
    end else if (kind < 15) begin
      nx = $urandom; ny = $urandom; nz = $urandom;
    end else if (kind < 22) begin
      // close to the pole, either side
      nx = $urandom_range(0, 6) - 3;
      ny = $urandom_range(0, 6) - 3;
      nz = ($urandom_range(0, 1) ? 16384 : -16384) + $urandom_range(0, 2) * (nz < 0 ? 1 : -1);
    end
    ox = in_range(); oy = in_range(); oz = in_range();
    if (kind >= 95) begin
      ox = $urandom; oy = $urandom; oz = $urandom;
    end
    return mk_req(nx, ny, nz, ox, oy, oz, $urandom, $urandom);
  endfunction

  function automatic int pick_gap();
    int p;
    if (steady) return 0;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
      req_gap     <= 0;
    end else begin
      if (req_valid_i && req_ready_o) begin
        expected_dirs.push_back(sample_dir(req_i));
        n_sent++;
      end
      if (!req_valid_i || req_ready_o) begin
        if (req_gap > 0) begin
          req_gap     <= req_gap - 1;
          req_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_i       <= pending_reqs.pop_front();
          req_valid_i <= 1'b1;
          req_gap     <= pick_gap();
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // response side
  always @(posedge clk_i or negedge rst_ni) begin
    chs_rsp_t want;
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
      rsp_stall   <= 0;
      hold_cycles <= 0;
    end else begin
      if (rsp_valid_o && rsp_ready_i) begin
        n_recv++;
        if (expected_dirs.size() == 0) begin
          $display("%0t: unexpected response, actual %0d %0d %0d", $realtime,
                   rsp_o.dir_x, rsp_o.dir_y, rsp_o.dir_z);
          n_errors++;
        end else begin
          want = expected_dirs.pop_front();
          if (rsp_o.dir_x !== want.dir_x) begin
            $display("%0t: dir_x expected %0d actual %0d", $realtime, want.dir_x, rsp_o.dir_x);
            n_errors++;
          end
          if (rsp_o.dir_y !== want.dir_y) begin
            $display("%0t: dir_y expected %0d actual %0d", $realtime, want.dir_y, rsp_o.dir_y);
            n_errors++;
          end
          if (rsp_o.dir_z !== want.dir_z) begin
            $display("%0t: dir_z expected %0d actual %0d", $realtime, want.dir_z, rsp_o.dir_z);
            n_errors++;
          end
        end
      end
      // one long hold-off mid-run so the pipeline backs up to the request side
      if (!hold_done && n_recv >= 400 && hold_cycles < HOLD_LEN) begin
        hold_cycles <= hold_cycles + 1;
        if (hold_cycles == HOLD_LEN - 1) hold_done <= 1'b1;
        rsp_ready_i <= 1'b0;
      end else if (rsp_stall > 0) begin
        rsp_stall   <= rsp_stall - 1;
        rsp_ready_i <= 1'b0;
      end else begin
        rsp_stall   <= pick_gap();
        rsp_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int n_dir;
    pending_reqs.push_back(mk_req(0, 0, -16384, 0, 0, -16384, 0, 0));          // degenerate frame
    pending_reqs.push_back(mk_req(0, 0, -16384, 0, 0, 16384, 65535, 65535));   // flipped to +z
    pending_reqs.push_back(mk_req(0, 0, 16384, 100, -200, -5, 32768, 'h2000));  // flipped to -z
    pending_reqs.push_back(mk_req(16384, 0, 0, 0, 16384, 0, 65535, 'h2001));    // zero dot
    pending_reqs.push_back(mk_req(-16384, 0, 0, -16384, 0, 0, 1, 'h4000));
    pending_reqs.push_back(mk_req(0, 16384, 0, 0, 16384, 0, 40000, 'h8000));
    pending_reqs.push_back(mk_req(0, -16384, 0, 3, -16384, 0, 12345, 'hC000));
    pending_reqs.push_back(mk_req(16384, 16384, -16383, 0, 0, -1, 20000, 'h1FFF)); // tiny d
    pending_reqs.push_back(mk_req(-16384, 16384, -16383, 0, 0, -1, 50000, 'h6000));
    pending_reqs.push_back(mk_req('h7FFF, 'h8000, 'h7FFF, 'h7FFF, 'h7FFF, 'h7FFF, 0, 'hFFFF));
    pending_reqs.push_back(mk_req('h8000, 'h8000, 'h8000, 'h8000, 'h8000, 'h8000, 65535, 0));
    pending_reqs.push_back(mk_req(0, 0, 16384, -16384, -16384, 16384, 65535, 'hA000));
    pending_reqs.push_back(mk_req(11585, 0, 11585, 16384, 16384, 16384, 16384, 'hE000));
    pending_reqs.push_back(mk_req(0, 0, 0, 0, 0, 0, 30000, 'h3000));
    pending_reqs.push_back(mk_req(1, -1, -16384, 0, 0, -16384, 65535, 'h5555));
    n_dir = pending_reqs.size();
    for (int i = 0; i < N_RANDOM; i++) pending_reqs.push_back(random_req());

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_reqs.size() > 0) begin
      // alternate spells of back-to-back traffic with randomly idled ones
      steady <= ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(50, 300)) @(posedge clk_i);
    end
    while (req_valid_i || expected_dirs.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d requests (%0d directed, %0d random), checked %0d responses.",
             n_sent, n_dir, N_RANDOM, n_recv);
    $display("Flipped normals: %0d, degenerate frames: %0d, mismatches: %0d.",
             n_flipped, n_degenerate, n_errors);
    if (n_errors == 0 && expected_dirs.size() == 0) begin
      $display("** cosine_hemisphere_sampler_top: PASSED **");
    end else begin
      $display("** cosine_hemisphere_sampler_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d responses outstanding.", expected_dirs.size());
    $display("** cosine_hemisphere_sampler_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
design/chs_pkg.sv
design/cosine_hemisphere_sampler_top.sv
tb/tb_cosine_hemisphere_sampler_top.sv
